// ===== rtl/tts_pkg.sv =====
// ----------------------------------------------------------------------------
// tts_pkg
// Shared types and constants of the tick task scheduler.
// ----------------------------------------------------------------------------
package tts_pkg;

  localparam int TASK_SLOTS_DEF = 8;
  localparam int CMD_W          = 2;
  localparam int ID_W           = 3;
  localparam int ARG_W          = 32;
  localparam int TIME_W         = 16;
  localparam int KIND_W         = 2;
  // wide enough to compare a slot number with any slot count up to 32
  localparam int SLOT_CMP_W     = 6;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD      = 2'd0,
    CMD_DELETE   = 2'd1,
    CMD_TICK     = 2'd2,
    CMD_DISPATCH = 2'd3
  } cmd_t;

  typedef enum logic [KIND_W-1:0] {
    EVT_COOP    = 2'd0,
    EVT_PREEMPT = 2'd1,
    EVT_IDLE    = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_IDLE_EVT
  } state_t;

endpackage

// ===== rtl/tts_ifs.sv =====
// ----------------------------------------------------------------------------
// tts channel interfaces
// Command channel and event channel, valid/ready with payload.
// ----------------------------------------------------------------------------
interface tts_cmd_if;
  import tts_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [ID_W-1:0]   task_id;
  logic              has_task;
  logic [ARG_W-1:0]  argument;
  logic [TIME_W-1:0] first_delay;
  logic [TIME_W-1:0] period;
  logic              preemptive;

  modport source (
    output valid, command, task_id, has_task, argument, first_delay, period, preemptive,
    input  ready
  );
  modport sink (
    input  valid, command, task_id, has_task, argument, first_delay, period, preemptive,
    output ready
  );
endinterface

interface tts_evt_if;
  import tts_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] event_kind;
  logic [ID_W-1:0]   run_slot;
  logic [ARG_W-1:0]  run_argument;
  logic              last;

  modport source (
    output valid, event_kind, run_slot, run_argument, last,
    input  ready
  );
  modport sink (
    input  valid, event_kind, run_slot, run_argument, last,
    output ready
  );
endinterface

// ===== rtl/tick_task_scheduler_unit.sv =====
// ----------------------------------------------------------------------------
// tick_task_scheduler_unit
// Task-slot scheduler with a slot-serial sequencer for tick and dispatch.
// ----------------------------------------------------------------------------
// Usage:
//   cmd (sink): add, delete, tick or dispatch transactions. evt (source):
//   run events (cooperative, pre-emptive or idle); last marks the final event
//   of one command.
//   Add and delete complete in the accept cycle and give no event; cmd.ready
//   stays high, so they can follow each other in back-to-back cycles.
//   Tick and dispatch start a sequencer that visits one slot per cycle while
//   the output register is not stalled; cmd.ready stays low until every slot
//   has been visited and its event, if any, handed to the output register.
//   A dispatch with nothing ready gives a single idle event and holds
//   cmd.ready low until that event is loaded into the output register.
//   Events leave from one output register; the first event appears the cycle
//   after its slot is visited. While evt.ready is low the sequencer waits on
//   the slot that wants to emit and resumes once the register frees up.
//   Reset (rst, synchronous) empties every slot, clears the ready and
//   pre-emptive masks and drops any pending event; no clearing pass follows.
// ----------------------------------------------------------------------------
module tick_task_scheduler_unit #(
  parameter int TASK_SLOTS = tts_pkg::TASK_SLOTS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  tts_cmd_if.sink   cmd,
  tts_evt_if.source evt
);
  import tts_pkg::*;

  localparam int IDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TASK_SLOTS - 1);

  // slot storage
  logic [TASK_SLOTS-1:0] slot_valid;
  logic [TASK_SLOTS-1:0] ready_mask;
  logic [TASK_SLOTS-1:0] preempt_mask;
  logic [ARG_W-1:0]      slot_argument [TASK_SLOTS];
  logic [TIME_W-1:0]     slot_delay    [TASK_SLOTS];
  logic [TIME_W-1:0]     slot_period   [TASK_SLOTS];

  // sequencer
  state_t                state;
  state_t                state_next;
  logic [IDX_W-1:0]      idx;
  logic                  scan_tick;
  logic [TASK_SLOTS-1:0] evt_mask;

  // output register
  logic                  out_valid;
  kind_t                 out_kind;
  logic [ID_W-1:0]       out_slot;
  logic [ARG_W-1:0]      out_arg;
  logic                  out_last;

  logic                  cmd_take;
  logic                  out_free;
  logic                  step;
  logic                  load_evt;
  logic                  id_ok;
  logic [IDX_W-1:0]      id_idx;
  cmd_t                  cmd_code;
  logic [TASK_SLOTS-1:0] zero_vec;
  logic [TASK_SLOTS-1:0] due_tick;
  logic [TASK_SLOTS-1:0] due_disp;
  logic [TASK_SLOTS-1:0] evt_above;
  logic                  scan_last;
  logic [TIME_W-1:0]     cur_delay;
  logic [TIME_W-1:0]     cur_period;

  assign cmd_code = cmd_t'(cmd.command);
  assign cmd_take = cmd.valid && cmd.ready;
  assign out_free = !out_valid || evt.ready;
  assign id_ok    = {{(SLOT_CMP_W-ID_W){1'b0}}, cmd.task_id} < SLOT_CMP_W'(TASK_SLOTS);
  assign id_idx   = IDX_W'(cmd.task_id);

  always_comb begin
    for (int s = 0; s < TASK_SLOTS; s++) begin
      zero_vec[s] = (slot_delay[s] == '0);
    end
  end

  assign due_tick   = slot_valid & zero_vec & preempt_mask;
  assign due_disp   = slot_valid & ready_mask & ~preempt_mask;
  assign evt_above  = evt_mask >> idx;
  assign scan_last  = ~|(evt_above >> 1);
  assign cur_delay  = slot_delay[idx];
  assign cur_period = slot_period[idx];

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd_take && cmd_code == CMD_TICK) begin
          state_next = ST_SCAN;
        end else if (cmd_take && cmd_code == CMD_DISPATCH) begin
          state_next = (ready_mask == '0) ? ST_IDLE_EVT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (step && idx == LAST_IDX) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE_EVT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    cmd.ready = 1'b0;
    step      = 1'b0;
    load_evt  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        cmd.ready = 1'b1;
      end
      ST_SCAN: begin
        step     = !evt_mask[idx] || out_free;
        load_evt = evt_mask[idx] && out_free;
      end
      ST_IDLE_EVT: begin
        load_evt = out_free;
      end
      default: begin
        cmd.ready = 1'b0;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      idx          <= '0;
      scan_tick    <= 1'b0;
      evt_mask     <= '0;
      slot_valid   <= '0;
      ready_mask   <= '0;
      preempt_mask <= '0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (load_evt) begin
        out_valid <= 1'b1;
      end else if (evt.ready) begin
        out_valid <= 1'b0;
      end

      if (cmd_take) begin
        idx       <= '0;
        scan_tick <= (cmd_code == CMD_TICK);
        evt_mask  <= (cmd_code == CMD_TICK) ? due_tick : due_disp;
        unique case (cmd_code)
          CMD_ADD: begin
            if (id_ok) begin
              ready_mask[id_idx]   <= (cmd.first_delay == '0);
              preempt_mask[id_idx] <= cmd.preemptive;
              if (cmd.has_task) begin
                slot_valid[id_idx] <= 1'b1;
              end
            end
          end
          CMD_DELETE: begin
            if (id_ok && slot_valid[id_idx]) begin
              slot_valid[id_idx]   <= 1'b0;
              ready_mask[id_idx]   <= 1'b0;
              preempt_mask[id_idx] <= 1'b0;
            end
          end
          CMD_TICK, CMD_DISPATCH: begin
          end
          default: begin
          end
        endcase
      end

      if (step) begin
        idx <= idx + IDX_W'(1);
        if (scan_tick) begin
          if (slot_valid[idx] && cur_delay == '0) begin
            if (preempt_mask[idx]) begin
              ready_mask[idx] <= 1'b0;
              if (cur_period == '0) begin
                slot_valid[idx] <= 1'b0;
              end
            end else begin
              ready_mask[idx] <= 1'b1;
            end
          end
        end else if (evt_mask[idx]) begin
          ready_mask[idx] <= 1'b0;
          if (cur_period == '0) begin
            slot_valid[idx] <= 1'b0;
          end
        end
      end
    end
  end

  // slot payload, read only where the slot holds a task
  always_ff @(posedge clk) begin
    if (cmd_take && cmd_code == CMD_ADD && id_ok) begin
      slot_argument[id_idx] <= cmd.argument;
      slot_period[id_idx]   <= cmd.period;
      slot_delay[id_idx]    <= (cmd.first_delay == '0) ? cmd.period : cmd.first_delay;
    end else if (step && scan_tick && slot_valid[idx]) begin
      if (cur_delay != '0) begin
        slot_delay[idx] <= cur_delay - TIME_W'(1);
      end else if (cur_period != '0) begin
        slot_delay[idx] <= cur_period - TIME_W'(1);
      end
    end
  end

  // event payload
  always_ff @(posedge clk) begin
    if (load_evt) begin
      if (state == ST_IDLE_EVT) begin
        out_kind <= EVT_IDLE;
        out_slot <= '0;
        out_arg  <= '0;
        out_last <= 1'b1;
      end else begin
        out_kind <= scan_tick ? EVT_PREEMPT : EVT_COOP;
        out_slot <= ID_W'(idx);
        out_arg  <= slot_argument[idx];
        out_last <= scan_last;
      end
    end
  end

  assign evt.valid        = out_valid;
  assign evt.event_kind   = out_kind;
  assign evt.run_slot     = out_slot;
  assign evt.run_argument = out_arg;
  assign evt.last         = out_last;

endmodule

// ===== rtl/tts_checker.sv =====
// ----------------------------------------------------------------------------
// tts_checker
// Port-level checks of the tick task scheduler, bound to the scheduler unit.
// ----------------------------------------------------------------------------
module tts_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      cmd_valid,
  input logic                      cmd_ready,
  input logic [tts_pkg::CMD_W-1:0] cmd_command,
  input logic                      evt_valid,
  input logic                      evt_ready,
  input logic [tts_pkg::KIND_W-1:0] evt_kind,
  input logic [tts_pkg::ID_W-1:0]  evt_slot,
  input logic [tts_pkg::ARG_W-1:0] evt_arg,
  input logic                      evt_last
);
  import tts_pkg::*;

  // a stalled event stays up
  a_evt_hold: assert property (@(posedge clk) disable iff (rst)
    evt_valid && !evt_ready |=> evt_valid)
    else $error("event dropped while stalled");

  // tick and dispatch keep the command channel busy
  a_busy_after_scan: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready &&
    (cmd_command == CMD_TICK || cmd_command == CMD_DISPATCH) |=> !cmd_ready)
    else $error("command accepted during a scan");

  // an idle event is empty and closes its command
  a_idle_shape: assert property (@(posedge clk) disable iff (rst)
    evt_valid && evt_kind == EVT_IDLE |-> evt_slot == '0 && evt_arg == '0 && evt_last)
    else $error("malformed idle event");

  // events are only produced while a command is being worked on
  a_evt_source: assert property (@(posedge clk) disable iff (rst)
    $rose(evt_valid) |-> $past(!cmd_ready))
    else $error("event raised while idle");

endmodule

bind tick_task_scheduler_unit tts_checker u_tts_checker (
  .clk         (clk),
  .rst         (rst),
  .cmd_valid   (cmd.valid),
  .cmd_ready   (cmd.ready),
  .cmd_command (cmd.command),
  .evt_valid   (evt.valid),
  .evt_ready   (evt.ready),
  .evt_kind    (evt.event_kind),
  .evt_slot    (evt.run_slot),
  .evt_arg     (evt.run_argument),
  .evt_last    (evt.last)
);

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the tick task scheduler. A slot-level scheduler
// model predicts the run events of every accepted command; the event
// monitor compares each event field by field with the oldest prediction.
// Directed tests cover the corner cases and a long output stall, then random
// traffic with idle gaps and back-to-back stretches.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import tts_pkg::*;

  localparam int SLOTS       = TASK_SLOTS_DEF;
  localparam int SETTLE      = 16;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    kind_t             kind;
    logic [ID_W-1:0]   slot;
    logic [ARG_W-1:0]  arg;
    logic              last;
  } run_event_t;

  logic clk;
  logic rst;

  tts_cmd_if cmd_if ();
  tts_evt_if evt_if ();

  tick_task_scheduler_unit dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_if),
    .evt (evt_if)
  );

  // scheduler model state
  logic              slot_live   [SLOTS];
  logic [SLOTS-1:0]  ready_bits;
  logic [SLOTS-1:0]  preempt_bits;
  logic [ARG_W-1:0]  slot_arg    [SLOTS];
  logic [TIME_W-1:0] slot_wait   [SLOTS];
  logic [TIME_W-1:0] slot_period [SLOTS];

  run_event_t due_events [$];
  run_event_t want_event;

  int  mismatch_count = 0;
  int  cycle_count    = 0;
  bit  tx_idle_en     = 1'b1;
  bit  rx_idle_en     = 1'b1;
  int  rx_stall_left  = 0;
  int  rx_hold_cycles = 0;
  int  rx_hold_left   = 0;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d events still expected", $time, due_events.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // apply one command to the model and queue the events it causes
  task automatic scheduler_step(cmd_t op, logic [ID_W-1:0] id, logic has,
                                logic [ARG_W-1:0] a, logic [TIME_W-1:0] dly,
                                logic [TIME_W-1:0] per, logic pre);
    run_event_t step_events [$];
    logic [TIME_W-1:0] load_wait;
    load_wait = dly;
    case (op)
      CMD_ADD: begin
        if (dly == '0) begin
          ready_bits[id] = 1'b1;
          load_wait      = per;
        end else begin
          ready_bits[id] = 1'b0;
        end
        preempt_bits[id] = pre;
        slot_arg[id]     = a;
        slot_wait[id]    = load_wait;
        slot_period[id]  = per;
        if (has) slot_live[id] = 1'b1;
      end
      CMD_DELETE: begin
        if (slot_live[id]) begin
          slot_live[id]    = 1'b0;
          slot_arg[id]     = '0;
          slot_period[id]  = '0;
          slot_wait[id]    = '0;
          ready_bits[id]   = 1'b0;
          preempt_bits[id] = 1'b0;
        end
      end
      CMD_TICK: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_live[i]) begin
            if (slot_wait[i] == '0) begin
              if (preempt_bits[i]) begin
                step_events.push_back('{EVT_PREEMPT, ID_W'(i), slot_arg[i], 1'b0});
                ready_bits[i] = 1'b0;
                if (slot_period[i] == '0) slot_live[i] = 1'b0;
              end else begin
                ready_bits[i] = 1'b1;
              end
              if (slot_period[i] != '0) slot_wait[i] = slot_period[i] - 1'b1;
            end else begin
              slot_wait[i] = slot_wait[i] - 1'b1;
            end
          end
        end
      end
      CMD_DISPATCH: begin
        if (ready_bits == '0) begin
          step_events.push_back('{EVT_IDLE, '0, '0, 1'b0});
        end else begin
          for (int i = 0; i < SLOTS; i++) begin
            if (ready_bits[i] && !preempt_bits[i] && slot_live[i]) begin
              step_events.push_back('{EVT_COOP, ID_W'(i), slot_arg[i], 1'b0});
              ready_bits[i] = 1'b0;
              if (slot_period[i] == '0) slot_live[i] = 1'b0;
            end
          end
        end
      end
      default: ;
    endcase
    if (step_events.size() > 0) step_events[step_events.size()-1].last = 1'b1;
    foreach (step_events[k]) due_events.push_back(step_events[k]);
  endtask

  // one command transaction; valid stays high until the next call or a pause
  task automatic send_command(cmd_t op, logic [ID_W-1:0] id, logic has,
                              logic [ARG_W-1:0] a, logic [TIME_W-1:0] dly,
                              logic [TIME_W-1:0] per, logic pre);
    int gap;
    gap = tx_idle_en ? $urandom_range(0, 13) : 0;
    @(negedge clk);
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_if.valid       <= 1'b1;
    cmd_if.command     <= op;
    cmd_if.task_id     <= id;
    cmd_if.has_task    <= has;
    cmd_if.argument    <= a;
    cmd_if.first_delay <= dly;
    cmd_if.period      <= per;
    cmd_if.preemptive  <= pre;
    do @(posedge clk); while (cmd_if.ready !== 1'b1);
    scheduler_step(op, id, has, a, dly, per, pre);
  endtask

  // tick and dispatch ignore the payload, so it carries random bits
  task automatic do_tick();
    send_command(CMD_TICK, ID_W'($urandom), 1'($urandom), $urandom,
                 TIME_W'($urandom), TIME_W'($urandom), 1'($urandom));
  endtask

  task automatic do_dispatch();
    send_command(CMD_DISPATCH, ID_W'($urandom), 1'($urandom), $urandom,
                 TIME_W'($urandom), TIME_W'($urandom), 1'($urandom));
  endtask

  task automatic pause_until_drained();
    @(negedge clk);
    cmd_if.valid <= 1'b0;
    while (due_events.size() != 0) @(posedge clk);
    // a tick with no due task still scans every slot
    repeat (SETTLE) @(posedge clk);
  endtask

  // mostly short delays so tasks fire often, sometimes the full range
  function automatic logic [TIME_W-1:0] draw_ticks();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) return TIME_W'($urandom_range(0, 3));
    if (sel < 8) return '0;
    return TIME_W'($urandom);
  endfunction

  function automatic void check_field(string what, logic [ARG_W-1:0] want_v,
                                      logic [ARG_W-1:0] got_v);
    if (got_v !== want_v) begin
      mismatch_count++;
      $display("%0t: %s mismatch: expected %h, actual %h", $time, what, want_v, got_v);
    end
  endfunction

  // event monitor
  always @(posedge clk) begin
    if (!rst && evt_if.valid === 1'b1 && evt_if.ready === 1'b1) begin
      rx_stall_left = rx_idle_en ? $urandom_range(0, 13) : 0;
      if (due_events.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected event: expected none, actual kind=%0d slot=%0d arg=%h",
                 $time, evt_if.event_kind, evt_if.run_slot, evt_if.run_argument);
      end else begin
        want_event = due_events.pop_front();
        check_field("event_kind", ARG_W'(want_event.kind), ARG_W'(evt_if.event_kind));
        check_field("run_slot", ARG_W'(want_event.slot), ARG_W'(evt_if.run_slot));
        check_field("run_argument", want_event.arg, evt_if.run_argument);
        check_field("last", ARG_W'(want_event.last), ARG_W'(evt_if.last));
      end
    end
  end

  // event receiver: random stalls per transaction, plus an occasional long hold
  always @(negedge clk) begin
    if (rx_hold_cycles > 0) begin
      rx_hold_left   = rx_hold_cycles;
      rx_hold_cycles = 0;
    end
    if (rst) begin
      evt_if.ready <= 1'b0;
    end else if (rx_hold_left > 0) begin
      evt_if.ready <= 1'b0;
      rx_hold_left--;
    end else if (rx_stall_left > 0) begin
      evt_if.ready <= 1'b0;
      rx_stall_left--;
    end else begin
      evt_if.ready <= 1'b1;
    end
  end

  task automatic test_empty_scheduler();
    do_tick();
    do_dispatch();
    pause_until_drained();
  endtask

  task automatic test_one_shot_tasks();
    send_command(CMD_ADD, 3'd0, 1'b1, 32'hFFFF_FFFF, 16'd0, 16'd0, 1'b0);
    send_command(CMD_ADD, 3'd7, 1'b1, 32'h0000_0000, 16'd0, 16'd0, 1'b1);
    do_dispatch();
    // only the pre-emptive slot is ready: no event at all
    do_dispatch();
    do_tick();
    do_dispatch();
    pause_until_drained();
  endtask

  task automatic test_missing_task();
    // ready bit without a task: dispatch skips it, delete ignores it
    send_command(CMD_ADD, 3'd2, 1'b0, 32'h1234_5678, 16'd0, 16'd0, 1'b0);
    do_dispatch();
    send_command(CMD_DELETE, 3'd2, 1'b0, 32'h0, 16'd0, 16'd0, 1'b0);
    send_command(CMD_ADD, 3'd4, 1'b1, 32'hA5A5_5A5A, 16'hFFFF, 16'hFFFF, 1'b1);
    do_tick();
    send_command(CMD_DELETE, 3'd4, 1'b1, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    pause_until_drained();
  endtask

  task automatic test_periodic_tasks();
    send_command(CMD_ADD, 3'd3, 1'b1, 32'h3333_3333, 16'd1, 16'd2, 1'b0);
    send_command(CMD_ADD, 3'd5, 1'b1, 32'h5555_5555, 16'd0, 16'd1, 1'b1);
    do_tick();
    do_tick();
    do_dispatch();
    do_tick();
    do_dispatch();
    pause_until_drained();
  endtask

  // every slot busy, receiver held off so the output register backs up
  task automatic test_output_stall();
    tx_idle_en = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      send_command(CMD_ADD, ID_W'(i), 1'b1, $urandom, 16'd0, 16'd1, (i % 3) == 0);
    end
    rx_hold_cycles = 300;
    do_dispatch();
    do_tick();
    do_tick();
    do_dispatch();
    do_tick();
    do_dispatch();
    pause_until_drained();
    tx_idle_en = 1'b1;
  endtask

  task automatic run_random_traffic(int count);
    int sel;
    repeat (count) begin
      sel = $urandom_range(0, 99);
      if (sel < 35) begin
        send_command(CMD_ADD, ID_W'($urandom), $urandom_range(0, 9) != 0, $urandom,
                     draw_ticks(), draw_ticks(), $urandom_range(0, 2) == 0);
      end else if (sel < 45) begin
        send_command(CMD_DELETE, ID_W'($urandom), 1'($urandom), $urandom,
                     TIME_W'($urandom), TIME_W'($urandom), 1'($urandom));
      end else if (sel < 75) begin
        do_tick();
      end else begin
        do_dispatch();
      end
    end
  endtask

  task automatic test_random_traffic();
    run_random_traffic(45);
    pause_until_drained();
    // back-to-back stretch with no idling on either side
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    run_random_traffic(30);
    pause_until_drained();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      slot_live[i]   = 1'b0;
      slot_arg[i]    = '0;
      slot_wait[i]   = '0;
      slot_period[i] = '0;
    end
    ready_bits   = '0;
    preempt_bits = '0;

    rst                = 1'b1;
    cmd_if.valid       = 1'b0;
    cmd_if.command     = CMD_ADD;
    cmd_if.task_id     = '0;
    cmd_if.has_task    = 1'b0;
    cmd_if.argument    = '0;
    cmd_if.first_delay = '0;
    cmd_if.period      = '0;
    cmd_if.preemptive  = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_scheduler();
    test_one_shot_tasks();
    test_missing_task();
    test_periodic_tasks();
    test_output_stall();
    test_random_traffic();

    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
